### sv/swsc_pkg.sv
// shared types and constants for the stack core
`default_nettype none
package swsc_pkg;

  typedef enum logic [2:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_SEARCH = 3'd2,
    KIND_DELVAL = 3'd3,
    KIND_DELEVN = 3'd4,
    KIND_DEDUPE = 3'd5,
    KIND_CLEAR  = 3'd6,
    KIND_NOP    = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POPRD,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_CMP_RD,
    S_CMP_CHK,
    S_DD_OUTER_RD,
    S_DD_OUTER_LAT,
    S_DD_INNER_RD,
    S_DD_INNER_CMP,
    S_RESULT
  } state_e;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 6;
  localparam int unsigned DepW  = 7;

endpackage
`default_nettype wire

### sv/swsc_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module swsc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### sv/stack_with_search_and_compaction_core.sv
// bounded lifo stack with search, delete and compaction over one ram
`default_nettype none
// Operations are handled one at a time. Push and clear act in the idle state
// and go straight to the result state; pop adds a state for its ram read. Search
// and delete value walk the entries from the top, a read and a compare per entry,
// then delete value shifts the entries above the match down one by one (a read
// and a write each). Delete evens walks the stack bottom up, a read and a check
// per entry. Dedupe compares each entry with every entry above it. All entries
// sit in one ram with a registered read, so every step is a read followed by a
// compare or a write. The operation kind travels on tuser and the value on tdata;
// tdata on the way out holds the result fields. Position wraps at its field width
// when DEPTH is above 64, depth when DEPTH is above 127.
module stack_with_search_and_compaction_core #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [31:0] s_tdata_i,  // value[31:0]
  input  wire logic [2:0]  s_tuser_i,  // kind[2:0]
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [55:0]      m_tdata_o   // popped[31:0], found[32], position[38:33],
                                       // status[40:39], depth[47:41], empty[48],
                                       // zero fill
);
  import swsc_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0] kind_q, kind_d;
  logic [DataW-1:0] val_q, val_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, w_q, w_d;
  logic [DataW-1:0] hold_q, hold_d;
  logic [DataW-1:0] popped_q, popped_d;
  logic found_q, found_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0] stat_q, stat_d;
  logic shift_q, shift_d;
  logic empty;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DataW-1:0] wdata, rdata;

  swsc_ram #(.Width(DataW), .Depth(DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = (state_q == S_RESULT);
  assign empty = (cnt_q == '0);
  assign m_tdata_o = {7'd0, empty, DepW'(cnt_q), stat_q, pos_q, found_q, popped_q};

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; kind_d = kind_q; val_d = val_q;
    i_d = i_q; j_d = j_q; w_d = w_q; hold_d = hold_q; popped_d = popped_q;
    found_d = found_q; pos_d = pos_q; stat_d = stat_q; shift_d = shift_q;
    we = 1'b0; waddr = '0; wdata = val_q; raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          kind_d = s_tuser_i;
          val_d = s_tdata_i;
          popped_d = '1; found_d = 1'b0; pos_d = '0; stat_d = ST_OK;
          shift_d = 1'b0;
          state_d = S_RESULT;
          unique case (kind_e'(s_tuser_i))
            KIND_PUSH: begin
              if (cnt_q == CW'(DEPTH)) stat_d = ST_OVERFLOW;
              else begin
                we = 1'b1; waddr = AW'(cnt_q); wdata = s_tdata_i;
                cnt_d = cnt_q + 1'b1;
              end
            end
            KIND_POP: begin
              if (cnt_q == '0) stat_d = ST_UNDERFLOW;
              else begin
                raddr = AW'(cnt_q - 1'b1);
                cnt_d = cnt_q - 1'b1;
                state_d = S_POPRD;
              end
            end
            KIND_SEARCH, KIND_DELVAL: begin
              i_d = '0; state_d = S_SRCH_RD;
            end
            KIND_DELEVN: begin
              i_d = '0; w_d = '0; state_d = S_CMP_RD;
            end
            KIND_DEDUPE: begin
              i_d = cnt_q; state_d = S_DD_OUTER_RD;
            end
            KIND_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      S_POPRD: begin
        popped_d = rdata; state_d = S_RESULT;
      end
      // walk from the top; i is distance from top
      S_SRCH_RD: begin
        if (i_q == cnt_q) state_d = S_RESULT;
        else begin
          raddr = AW'(cnt_q - 1'b1 - i_q);
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (rdata == val_q) begin
          found_d = 1'b1; pos_d = PosW'(i_q);
          if (kind_q == KIND_DELVAL) begin
            // shift entries above the match down; w is write slot
            w_d = cnt_q - 1'b1 - i_q; j_d = cnt_q - i_q;
            i_d = cnt_q; shift_d = 1'b1;
            state_d = S_DD_INNER_RD;
          end else state_d = S_RESULT;
        end else begin
          i_d = i_q + 1'b1; state_d = S_SRCH_RD;
        end
      end
      // delete evens: i read slot, w write slot
      S_CMP_RD: begin
        if (i_q == cnt_q) begin
          cnt_d = w_q; state_d = S_RESULT;
        end else begin
          raddr = AW'(i_q); state_d = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        if (rdata[0]) begin
          we = 1'b1; waddr = AW'(w_q); wdata = rdata; w_d = w_q + 1'b1;
        end
        i_d = i_q + 1'b1; state_d = S_CMP_RD;
      end
      // dedupe: i outer index (exclusive), j scans above
      S_DD_OUTER_RD: begin
        if (i_q == '0) state_d = S_RESULT;
        else begin
          raddr = AW'(i_q - 1'b1); i_d = i_q - 1'b1;
          state_d = S_DD_OUTER_LAT;
        end
      end
      S_DD_OUTER_LAT: begin
        hold_d = rdata; j_d = i_q + 1'b1; state_d = S_DD_INNER_RD;
      end
      S_DD_INNER_RD: begin
        if (j_q >= cnt_q) begin
          if (shift_q) begin
            cnt_d = cnt_q - 1'b1; shift_d = 1'b0;
            state_d = (kind_q == KIND_DELVAL) ? S_RESULT : S_DD_OUTER_RD;
            i_d = i_q;
          end else state_d = S_DD_OUTER_RD;
        end else begin
          raddr = AW'(j_q); state_d = S_DD_INNER_CMP;
        end
      end
      S_DD_INNER_CMP: begin
        if (shift_q) begin
          we = 1'b1; waddr = AW'(w_q); wdata = rdata;
          w_d = w_q + 1'b1; j_d = j_q + 1'b1; state_d = S_DD_INNER_RD;
        end else if (rdata == hold_q) begin
          // drop slot i: shift everything above down by one
          shift_d = 1'b1; w_d = i_q; j_d = i_q + 1'b1;
          state_d = S_DD_INNER_RD;
        end else begin
          j_d = j_q + 1'b1; state_d = S_DD_INNER_RD;
        end
      end
      S_RESULT: begin
        if (m_tready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      shift_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; val_q <= val_d; i_q <= i_d; j_q <= j_d; w_q <= w_d;
    hold_q <= hold_d; popped_q <= popped_d; found_q <= found_d;
    pos_q <= pos_d; stat_q <= stat_d;
  end
endmodule
`default_nettype wire

### tb/tb_stack_with_search_and_compaction_core.sv
// testbench for the stack core: directed table, then random operations checked by a predictor
`timescale 1ns / 1ps
module tb_stack_with_search_and_compaction_core;
  import swsc_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;

  typedef struct packed {
    logic        empty_res;
    logic [6:0]  depth;
    logic [1:0]  status;
    logic [5:0]  position;
    logic        found;
    logic [31:0] popped;
  } stack_res_t;

  typedef struct {
    kind_e       kind;
    logic [31:0] value;
    bit          typed;
    stack_res_t  res;
  } op_row_t;

  logic        clk_i, rst_ni;
  logic        s_tvalid_i, s_tready_o;
  logic [31:0] s_tdata_i;
  logic [2:0]  s_tuser_i;
  logic        m_tvalid_o, m_tready_i;
  logic [55:0] m_tdata_o;

  stack_with_search_and_compaction_core #(.DEPTH(STACK_DEPTH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid_i(s_tvalid_i), .s_tready_o(s_tready_o), .s_tdata_i(s_tdata_i),
    .s_tuser_i(s_tuser_i),
    .m_tvalid_o(m_tvalid_o), .m_tready_i(m_tready_i), .m_tdata_o(m_tdata_o)
  );

  // predictor state: slot 0 is the bottom
  logic [31:0] stk_mem [STACK_DEPTH];
  int unsigned stk_cnt;
  stack_res_t  pending_q[$];
  int unsigned errors, n_sent, n_checked, n_full, n_empty_pop, n_dedupe;
  int unsigned send_idle, recv_idle;
  bit          hold_req;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("tb_stack_with_search_and_compaction_core: FAIL");
    $finish;
  end

  function automatic void drop_slot(int unsigned slot);
    for (int unsigned i = slot; i + 1 < stk_cnt; i++) stk_mem[i] = stk_mem[i + 1];
    stk_cnt--;
  endfunction

  function automatic stack_res_t apply_op(kind_e kind, logic [31:0] v);
    stack_res_t r;
    int unsigned w;
    bit hit;
    r = '{popped: 32'hFFFF_FFFF, found: 1'b0, position: '0, status: ST_OK, depth: '0,
          empty_res: 1'b0};
    case (kind)
      KIND_PUSH: begin
        if (stk_cnt >= STACK_DEPTH) begin
          r.status = ST_OVERFLOW;
          n_full++;
        end else begin
          stk_mem[stk_cnt] = v;
          stk_cnt++;
        end
      end
      KIND_POP: begin
        if (stk_cnt == 0) begin
          r.status = ST_UNDERFLOW;
          n_empty_pop++;
        end else begin
          stk_cnt--;
          r.popped = stk_mem[stk_cnt];
        end
      end
      KIND_SEARCH, KIND_DELVAL: begin
        for (int unsigned k = 0; k < stk_cnt; k++) begin
          if (stk_mem[stk_cnt - 1 - k] == v) begin
            r.found = 1'b1;
            r.position = k[5:0];
            if (kind == KIND_DELVAL) drop_slot(stk_cnt - 1 - k);
            break;
          end
        end
      end
      KIND_DELEVN: begin
        w = 0;
        for (int unsigned i = 0; i < stk_cnt; i++)
          if (stk_mem[i][0]) begin
            stk_mem[w] = stk_mem[i];
            w++;
          end
        stk_cnt = w;
      end
      KIND_DEDUPE: begin
        n_dedupe++;
        for (int i = int'(stk_cnt) - 1; i >= 0; i--) begin
          hit = 1'b0;
          for (int unsigned j = i + 1; j < stk_cnt; j++)
            if (stk_mem[j] == stk_mem[i]) hit = 1'b1;
          if (hit) drop_slot(i);
        end
      end
      KIND_CLEAR: stk_cnt = 0;
      default: ;
    endcase
    r.depth = stk_cnt[6:0];
    r.empty_res = (stk_cnt == 0);
    return r;
  endfunction

  // drive one operation and record its expectation at the accepting edge
  task automatic send_op(op_row_t row);
    stack_res_t r;
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    s_tvalid_i = 1'b1;
    s_tdata_i  = row.value;
    s_tuser_i  = row.kind;
    do @(posedge clk_i); while (!s_tready_o);
    r = apply_op(row.kind, row.value);
    pending_q.push_back(row.typed ? row.res : r);
    n_sent++;
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
  endtask

  // receiver side: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready_i = 1'b0;
    end else begin
      m_tready_i = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    stack_res_t got, want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = m_tdata_o[48:0];
      if (pending_q.size() == 0) begin
        $error("result with no operation outstanding: %h", m_tdata_o);
        errors++;
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        if (got.popped !== want.popped) begin
          $error("popped: expected %h, got %h", want.popped, got.popped); errors++;
        end
        if (got.found !== want.found) begin
          $error("found: expected %b, got %b", want.found, got.found); errors++;
        end
        if (got.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, got.position); errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status); errors++;
        end
        if (got.depth !== want.depth) begin
          $error("depth: expected %0d, got %0d", want.depth, got.depth); errors++;
        end
        if (got.empty_res !== want.empty_res) begin
          $error("empty_res: expected %b, got %b", want.empty_res, got.empty_res);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_value();
    logic [31:0] pool [8] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF,
                              32'h8000_0000, 32'h7FFF_FFFF, 32'd6};
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 30 && stk_cnt > 0) return stk_mem[$urandom_range(stk_cnt - 1)];
    if (sel < 75) return pool[$urandom_range(7)];
    return $urandom();
  endfunction

  function automatic kind_e rand_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return KIND_PUSH;
    if (r < 58) return KIND_POP;
    if (r < 72) return KIND_SEARCH;
    if (r < 84) return KIND_DELVAL;
    if (r < 89) return KIND_DELEVN;
    if (r < 94) return KIND_DEDUPE;
    if (r < 97) return KIND_CLEAR;
    return KIND_NOP;
  endfunction

  function automatic op_row_t mk(kind_e k, logic [31:0] v);
    return '{kind: k, value: v, typed: 1'b0, res: '0};
  endfunction

  function automatic op_row_t mkt(kind_e k, logic [31:0] v, logic [31:0] p, logic f,
                                  logic [5:0] pos, status_e s, logic [6:0] d);
    return '{kind: k, value: v, typed: 1'b1,
             res: '{popped: p, found: f, position: pos, status: s, depth: d,
                    empty_res: (d == 7'd0)}};
  endfunction

  initial begin
    op_row_t dir_tbl[$];
    op_row_t row;
    int unsigned waited;
    errors = 0; n_sent = 0; n_checked = 0; n_full = 0; n_empty_pop = 0; n_dedupe = 0;
    stk_cnt = 0; hold_req = 1'b0; hold_left = 0;
    send_idle = 22; recv_idle = 50;
    s_tvalid_i = 1'b0; s_tdata_i = '0; s_tuser_i = '0; m_tready_i = 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    dir_tbl = '{
      mkt(KIND_POP,    32'd5,         32'hFFFF_FFFF, 1'b0, 6'd0, ST_UNDERFLOW, 7'd0),
      mkt(KIND_SEARCH, 32'd0,         32'hFFFF_FFFF, 1'b0, 6'd0, ST_OK, 7'd0),
      mkt(KIND_PUSH,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 6'd0, ST_OK, 7'd1),
      mkt(KIND_PUSH,   32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 6'd0, ST_OK, 7'd2),
      mkt(KIND_PUSH,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 6'd0, ST_OK, 7'd3),
      mkt(KIND_PUSH,   32'd0,         32'hFFFF_FFFF, 1'b0, 6'd0, ST_OK, 7'd4),
      mkt(KIND_SEARCH, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 6'd3, ST_OK, 7'd4),
      mk(KIND_PUSH,    32'h8000_0000),
      mk(KIND_PUSH,    32'hFFFF_FFFE),
      mk(KIND_SEARCH,  32'h8000_0000),
      mk(KIND_SEARCH,  32'h1234_5678),
      mk(KIND_DEDUPE,  32'd0),
      mk(KIND_DELVAL,  32'hFFFF_FFFF),
      mk(KIND_DELVAL,  32'd99),
      mk(KIND_PUSH,    32'd7),
      mk(KIND_PUSH,    32'd7),
      mk(KIND_DELEVN,  32'd0),
      mk(KIND_NOP,     32'hA5A5_A5A5),
      mk(KIND_POP,     32'd0),
      mkt(KIND_CLEAR,  32'd0,         32'hFFFF_FFFF, 1'b0, 6'd0, ST_OK, 7'd0),
      mkt(KIND_DELEVN, 32'd0,         32'hFFFF_FFFF, 1'b0, 6'd0, ST_OK, 7'd0)
    };
    foreach (dir_tbl[i]) send_op(dir_tbl[i]);

    // fill to the top and beyond so pushes get dropped
    for (int i = 0; i < 68; i++) send_op(mk(KIND_PUSH, rand_value()));
    send_op(mk(KIND_DEDUPE, 32'd0));

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 22 : (ph == 1) ? 50 : 0;
      recv_idle = (ph == 0) ? 50 : (ph == 1) ? 22 : 0;
      if (ph == 1) hold_req = 1'b1;
      for (int i = 0; i < 55; i++) begin
        // occasional push bursts keep the stack deep enough to matter
        if ($urandom_range(19) == 0)
          repeat ($urandom_range(30, 5)) send_op(mk(KIND_PUSH, rand_value()));
        else
          send_op(mk(rand_kind(), rand_value()));
      end
      if (ph == 1) repeat (10) send_op(mk(KIND_POP, 32'd0));
    end
    send_op(mk(KIND_CLEAR, 32'd0));
    repeat (3) send_op(mk(KIND_POP, 32'd0));

    waited = 0;
    while (pending_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $error("%0d results never arrived", pending_q.size());
      errors++;
    end
    $display("covered %0d operations, %0d results checked", n_sent, n_checked);
    $display("dropped pushes %0d, empty pops %0d, dedupes %0d", n_full, n_empty_pop, n_dedupe);
    if (errors == 0) begin
      $display("tb_stack_with_search_and_compaction_core: PASS");
    end else begin
      $display("tb_stack_with_search_and_compaction_core: FAIL");
    end
    $finish;
  end

endmodule

### stack_with_search_and_compaction_core.f
sv/swsc_pkg.sv
sv/swsc_ram.sv
sv/stack_with_search_and_compaction_core.sv
tb/tb_stack_with_search_and_compaction_core.sv
